>>> design/sxdt1_pkg.sv
// ---------------------------------------------------------------------------
// sxdt1_pkg
// Shared types, constants and the microcode store of the DT1 frame builder.
// ---------------------------------------------------------------------------
package sxdt1_pkg;

    localparam int ADDR_W   = 32;
    localparam int VALUE_W  = 32;
    localparam int SIZE_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int DEV_W    = 7;
    localparam int MODEL_W  = 32;
    localparam int SUM_W    = 7;
    localparam int NIB_W    = 3;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MODEL_ID  = CFG_IDX_W'(1);

    localparam logic [DEV_W-1:0]   DEVICE_ID_RESET = DEV_W'(0);
    localparam logic [MODEL_W-1:0] MODEL_ID_RESET  = MODEL_W'(32'h0000_0069);

    localparam logic [BYTE_W-1:0] FRAME_START  = 8'hF0;
    localparam logic [BYTE_W-1:0] FRAME_END    = 8'hF7;
    localparam logic [BYTE_W-1:0] MAKER_BYTE   = 8'h41;
    localparam logic [BYTE_W-1:0] CMD_DATA_SET = 8'h12;

    localparam logic [SIZE_W-1:0] SIZE_7BIT  = 3'd0;
    localparam logic [SIZE_W-1:0] SIZE_NIB2  = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_NIB3  = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_NIB4  = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_NIB8  = 3'd4;

    localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_DEV,
        SRC_MODEL,
        SRC_ADDR,
        SRC_DATA,
        SRC_CSUM
    } t_src;

    typedef enum logic [1:0] {
        JMP_WAIT,   // hold until a request is loaded
        JMP_NEXT,
        JMP_LOOP,   // repeat while data nibbles remain
        JMP_IDLE
    } t_jmp;

    typedef struct packed {
        t_src              src;
        logic [BYTE_W-1:0] cbyte;
        logic              add_sum;
        logic              shift;
        logic              last;
        t_jmp              jmp;
    } t_uop;

    // sequencer -> datapath
    typedef struct packed {
        t_uop uop;
        logic fire;
    } t_ctl;

    // datapath -> sequencer
    typedef struct packed {
        logic out_free;
        logic nib_done;
    } t_stat;

    function automatic logic size_ok(input logic [SIZE_W-1:0] size);
        return (size == SIZE_7BIT) || (size == SIZE_NIB2) || (size == SIZE_NIB3) ||
               (size == SIZE_NIB4) || (size == SIZE_NIB8);
    endfunction

    function automatic t_uop op(input t_src src, input logic [BYTE_W-1:0] cbyte,
                                input logic add_sum, input logic shift,
                                input logic last, input t_jmp jmp);
        t_uop u;
        u.src     = src;
        u.cbyte   = cbyte;
        u.add_sum = add_sum;
        u.shift   = shift;
        u.last    = last;
        u.jmp     = jmp;
        return u;
    endfunction

    // microcode store, one word per step
    function automatic t_uop uc_rom(input logic [STEP_W-1:0] step);
        t_uop u;
        u = op(SRC_CONST, '0, 1'b0, 1'b0, 1'b0, JMP_WAIT);
        case (step)
            4'd1:    u = op(SRC_CONST, FRAME_START,  1'b0, 1'b0, 1'b0, JMP_NEXT);
            4'd2:    u = op(SRC_CONST, MAKER_BYTE,   1'b0, 1'b0, 1'b0, JMP_NEXT);
            4'd3:    u = op(SRC_DEV,   '0,           1'b0, 1'b0, 1'b0, JMP_NEXT);
            4'd4,
            4'd5,
            4'd6,
            4'd7:    u = op(SRC_MODEL, '0,           1'b0, 1'b1, 1'b0, JMP_NEXT);
            4'd8:    u = op(SRC_CONST, CMD_DATA_SET, 1'b0, 1'b0, 1'b0, JMP_NEXT);
            4'd9,
            4'd10,
            4'd11,
            4'd12:   u = op(SRC_ADDR,  '0,           1'b1, 1'b1, 1'b0, JMP_NEXT);
            4'd13:   u = op(SRC_DATA,  '0,           1'b1, 1'b1, 1'b0, JMP_LOOP);
            4'd14:   u = op(SRC_CSUM,  '0,           1'b0, 1'b0, 1'b0, JMP_NEXT);
            4'd15:   u = op(SRC_CONST, FRAME_END,    1'b0, 1'b0, 1'b1, JMP_IDLE);
            default: u = op(SRC_CONST, '0,           1'b0, 1'b0, 1'b0, JMP_WAIT);
        endcase
        return u;
    endfunction

endpackage

>>> design/sxdt1_in_if.sv
// ---------------------------------------------------------------------------
// sxdt1_in_if
// Request channel: one parameter write per request.
// ---------------------------------------------------------------------------
interface sxdt1_in_if;
    logic                           valid;
    logic                           ready;
    logic [sxdt1_pkg::ADDR_W-1:0]   address;
    logic [sxdt1_pkg::SIZE_W-1:0]   size_code;
    logic [sxdt1_pkg::VALUE_W-1:0]  value;

    modport source (output valid, address, size_code, value, input ready);
    modport sink   (input valid, address, size_code, value, output ready);
endinterface

>>> design/sxdt1_out_if.sv
// ---------------------------------------------------------------------------
// sxdt1_out_if
// Frame byte channel: one byte of the frame per transfer.
// ---------------------------------------------------------------------------
interface sxdt1_out_if;
    logic                          valid;
    logic                          ready;
    logic [sxdt1_pkg::BYTE_W-1:0]  frame_byte;
    logic                          last;

    modport source (output valid, frame_byte, last, input ready);
    modport sink   (input valid, frame_byte, last, output ready);
endinterface

>>> design/sxdt1_seq.sv
// ---------------------------------------------------------------------------
// sxdt1_seq
// Step counter and microcode fetch; resolves jumps from datapath status.
// ---------------------------------------------------------------------------
module sxdt1_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sxdt1_pkg::t_stat  i_stat,
    output logic              o_idle,
    output sxdt1_pkg::t_ctl   o_ctl
);
    import sxdt1_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uop              uop;
    logic              fire;

    assign uop    = uc_rom(r_step);
    assign o_idle = (r_step == STEP_IDLE);
    // every step but the wait step emits one byte, gated by output space
    assign fire   = (uop.jmp != JMP_WAIT) && i_stat.out_free;

    assign o_ctl.uop  = uop;
    assign o_ctl.fire = fire;

    always_comb begin
        n_step = r_step;
        case (uop.jmp)
            JMP_WAIT: begin
                if (i_load) begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            JMP_NEXT: begin
                if (fire) begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            JMP_LOOP: begin
                if (fire && i_stat.nib_done) begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            JMP_IDLE: begin
                if (fire) begin
                    n_step = STEP_IDLE;
                end
            end
            default: n_step = STEP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == STEP_IDLE && !i_load) |=> (r_step == STEP_IDLE))
        else $error("sequencer left idle without a request");

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STEP_IDLE && !i_stat.out_free) |=> $stable(r_step))
        else $error("step advanced while output was full");

    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> (r_step != STEP_IDLE))
        else $error("byte emitted from idle step");

endmodule

>>> design/sxdt1_dp.sv
// ---------------------------------------------------------------------------
// sxdt1_dp
// Frame datapath: operand shifters, checksum accumulator, output register.
// ---------------------------------------------------------------------------
module sxdt1_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [sxdt1_pkg::ADDR_W-1:0]   i_address,
    input  logic [sxdt1_pkg::SIZE_W-1:0]   i_size_code,
    input  logic [sxdt1_pkg::VALUE_W-1:0]  i_value,
    input  logic [sxdt1_pkg::DEV_W-1:0]    i_device_id,
    input  logic [sxdt1_pkg::MODEL_W-1:0]  i_model_id,
    input  sxdt1_pkg::t_ctl                i_ctl,
    input  logic                           i_out_ready,
    output sxdt1_pkg::t_stat               o_stat,
    output logic                           o_out_valid,
    output logic [sxdt1_pkg::BYTE_W-1:0]   o_frame_byte,
    output logic                           o_last
);
    import sxdt1_pkg::*;

    logic [ADDR_W-1:0]  r_addr;
    logic [MODEL_W-1:0] r_model;
    logic [VALUE_W-1:0] r_val;
    logic [NIB_W-1:0]   r_nib;
    logic               r_mode7;
    logic [SUM_W-1:0]   r_sum;
    logic               r_ovalid;
    logic [BYTE_W-1:0]  r_obyte;
    logic               r_olast;

    logic [VALUE_W-1:0] val_aligned;
    logic [NIB_W-1:0]   nib_init;
    logic [BYTE_W-1:0]  byte_sel;

    // value is left-aligned so the next data byte always sits at the top
    always_comb begin
        case (i_size_code)
            SIZE_NIB2: begin
                val_aligned = {i_value[7:0], 24'b0};
                nib_init    = NIB_W'(1);
            end
            SIZE_NIB3: begin
                val_aligned = {i_value[11:0], 20'b0};
                nib_init    = NIB_W'(2);
            end
            SIZE_NIB4: begin
                val_aligned = {i_value[15:0], 16'b0};
                nib_init    = NIB_W'(3);
            end
            SIZE_NIB8: begin
                val_aligned = i_value;
                nib_init    = NIB_W'(7);
            end
            default: begin
                val_aligned = {i_value[6:0], 25'b0};
                nib_init    = NIB_W'(0);
            end
        endcase
    end

    always_comb begin
        case (i_ctl.uop.src)
            SRC_CONST: byte_sel = i_ctl.uop.cbyte;
            SRC_DEV:   byte_sel = {1'b0, i_device_id};
            SRC_MODEL: byte_sel = r_model[MODEL_W-1 -: BYTE_W];
            SRC_ADDR:  byte_sel = r_addr[ADDR_W-1 -: BYTE_W];
            SRC_DATA:  byte_sel = r_mode7 ? {1'b0, r_val[VALUE_W-1 -: 7]}
                                          : {4'b0, r_val[VALUE_W-1 -: 4]};
            SRC_CSUM:  byte_sel = {1'b0, SUM_W'(-r_sum)};
            default:   byte_sel = '0;
        endcase
    end

    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_stat.nib_done = (r_nib == '0);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_addr  <= i_address;
            r_model <= i_model_id;
            r_val   <= val_aligned;
            r_nib   <= nib_init;
            r_mode7 <= (i_size_code == SIZE_7BIT);
            r_sum   <= '0;
        end else if (i_ctl.fire) begin
            if (i_ctl.uop.add_sum) begin
                r_sum <= r_sum + byte_sel[SUM_W-1:0];
            end
            if (i_ctl.uop.shift) begin
                case (i_ctl.uop.src)
                    SRC_MODEL: r_model <= r_model << BYTE_W;
                    SRC_ADDR:  r_addr  <= r_addr << BYTE_W;
                    SRC_DATA: begin
                        r_val <= r_val << 4;
                        r_nib <= r_nib - NIB_W'(1);
                    end
                    default: r_sum <= r_sum;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctl.fire) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire) begin
            r_obyte <= byte_sel;
            r_olast <= i_ctl.uop.last;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_frame_byte = r_obyte;
    assign o_last       = r_olast;

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> (r_obyte == FRAME_END))
        else $error("last flag on a byte other than frame end");

    a_csum_7bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fire && i_ctl.uop.src == SRC_CSUM) |=> (r_obyte[BYTE_W-1] == 1'b0))
        else $error("checksum byte above 127");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load && i_ctl.fire))
        else $error("request loaded while a frame byte was emitted");

endmodule

>>> design/sxdt1_frame_builder.sv
// ---------------------------------------------------------------------------
// sysex_dt1_frame_builder
// Builds a system-exclusive data-set frame with checksum per parameter write.
// ---------------------------------------------------------------------------
//  channel   dir  payload                          handshake
//  i_req     in   address, size_code, value        valid/ready
//  o_rsp     out  frame_byte, last                 valid/ready
//  i_cfg_*   in   idx 0 device_id, 1 model_id      write enable, no wait
//
//  A frame is 15 to 22 bytes; the microcode sequencer runs one step per byte,
//  after the idle step in which the request is accepted.
//  Requests are taken only in the idle step; the closing byte may still sit
//  in the output register when the next request is taken.
//  An output stall freezes the step counter. Reset is synchronous, active low,
//  and clears the sequencer and output valid. Size codes above 4 are dropped.
// ---------------------------------------------------------------------------
module sysex_dt1_frame_builder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sxdt1_in_if.sink                           i_req,
    sxdt1_out_if.source                        o_rsp,
    input  logic                               i_cfg_we,
    input  logic [sxdt1_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sxdt1_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sxdt1_pkg::*;

    logic [DEV_W-1:0]   r_device_id;
    logic [MODEL_W-1:0] r_model_id;
    logic               idle;
    logic               load;
    t_ctl               ctl;
    t_stat              stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= DEVICE_ID_RESET;
            r_model_id  <= MODEL_ID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEVICE_ID: r_device_id <= i_cfg_data[DEV_W-1:0];
                CFG_MODEL_ID:  r_model_id  <= i_cfg_data[MODEL_W-1:0];
                default:       r_device_id <= r_device_id;
            endcase
        end
    end

    assign i_req.ready = idle;
    assign load        = i_req.valid && idle && size_ok(i_req.size_code);

    sxdt1_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_stat  (stat),
        .o_idle  (idle),
        .o_ctl   (ctl)
    );

    sxdt1_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_address    (i_req.address),
        .i_size_code  (i_req.size_code),
        .i_value      (i_req.value),
        .i_device_id  (r_device_id),
        .i_model_id   (r_model_id),
        .i_ctl        (ctl),
        .i_out_ready  (o_rsp.ready),
        .o_stat       (stat),
        .o_out_valid  (o_rsp.valid),
        .o_frame_byte (o_rsp.frame_byte),
        .o_last       (o_rsp.last)
    );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DT1 frame builder. Parameter writes are queued
// by the stimulus process and sent by a clocked driver. Each accepted write is
// expanded into its expected frame bytes. A clocked monitor compares every
// frame byte with the oldest expected one. Both channels idle at random, and
// the device and model registers are rewritten between phases.
// ---------------------------------------------------------------------------
module tb_top;
    import sxdt1_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;

    // indexes past the register list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

    typedef struct {
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
        logic [VALUE_W-1:0] value;
    } t_param_write;

    typedef struct {
        logic [BYTE_W-1:0] fbyte;
        logic              last;
    } t_frame_byte;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    sxdt1_in_if  req_if ();
    sxdt1_out_if rsp_if ();

    sysex_dt1_frame_builder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // bench copy of the registers
    logic [DEV_W-1:0]   dev_id_copy;
    logic [MODEL_W-1:0] model_id_copy;

    t_param_write write_q[$];
    t_frame_byte  frame_q[$];
    t_param_write cur_write;
    t_frame_byte  want;

    int  pending_cnt;
    int  err_cnt;
    int  req_gap;
    int  rsp_stall;
    int  idle_cycles;
    bit  req_calm;
    bit  rsp_calm;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void put_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_frame_byte fb;
        fb.fbyte = b;
        fb.last  = last;
        frame_q.insert(frame_q.size(), fb);
    endfunction

    // expand one parameter write into the bytes of its data-set frame
    function automatic void build_frame(input t_param_write w);
        logic [SUM_W-1:0]  csum_acc;
        logic [BYTE_W-1:0] b;
        int                nibbles;
        csum_acc = '0;
        case (w.size)
            SIZE_7BIT: nibbles = 0;
            SIZE_NIB2: nibbles = 2;
            SIZE_NIB3: nibbles = 3;
            SIZE_NIB4: nibbles = 4;
            SIZE_NIB8: nibbles = 8;
            default:   return;   // unused size code: dropped silently
        endcase
        put_frame_byte(FRAME_START, 1'b0);
        put_frame_byte(MAKER_BYTE, 1'b0);
        put_frame_byte({1'b0, dev_id_copy}, 1'b0);
        for (int i = 3; i >= 0; i--) put_frame_byte(model_id_copy[8*i +: 8], 1'b0);
        put_frame_byte(CMD_DATA_SET, 1'b0);
        for (int i = 3; i >= 0; i--) begin
            b = w.addr[8*i +: 8];
            csum_acc = csum_acc + b[SUM_W-1:0];
            put_frame_byte(b, 1'b0);
        end
        if (nibbles == 0) begin
            b = {1'b0, w.value[6:0]};
            csum_acc = csum_acc + b[SUM_W-1:0];
            put_frame_byte(b, 1'b0);
        end else begin
            for (int i = nibbles - 1; i >= 0; i--) begin
                b = {4'h0, w.value[4*i +: 4]};
                csum_acc = csum_acc + b[SUM_W-1:0];
                put_frame_byte(b, 1'b0);
            end
        end
        csum_acc = SUM_W'(0) - csum_acc;
        put_frame_byte({1'b0, csum_acc}, 1'b0);
        put_frame_byte(FRAME_END, 1'b1);
    endfunction

    function automatic void report_error(input string msg);
        if (err_cnt < MAX_REPORTS) $display("%0t ERROR: %s", $realtime, msg);
        err_cnt++;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_gap = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                build_frame(cur_write);
                pending_cnt--;
                req_gap = pick_gap(req_calm);
                if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
            end
            if (!(req_if.valid && !req_if.ready)) begin
                if (req_gap > 0) begin
                    req_gap--;
                    req_if.valid <= 1'b0;
                end else if (write_q.size() > 0) begin
                    cur_write = write_q.pop_front();
                    req_if.address   <= cur_write.addr;
                    req_if.size_code <= cur_write.size;
                    req_if.value     <= cur_write.value;
                    req_if.valid     <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // frame byte monitor and backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rsp_stall = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (frame_q.size() == 0) begin
                    report_error($sformatf("unexpected byte %02h last %0b",
                                           rsp_if.frame_byte, rsp_if.last));
                end else begin
                    want = frame_q.pop_front();
                    if (rsp_if.frame_byte !== want.fbyte || rsp_if.last !== want.last)
                        report_error($sformatf("expected %02h last %0b, got %02h last %0b",
                                               want.fbyte, want.last,
                                               rsp_if.frame_byte, rsp_if.last));
                end
                rsp_stall = pick_gap(rsp_calm);
                if ($urandom_range(0, 99) == 0) rsp_calm = !rsp_calm;
            end
            if (rsp_stall > 0) begin
                rsp_stall--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted request or byte
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t ERROR: no progress for %0d cycles", $realtime, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size,
                              input logic [VALUE_W-1:0] value);
        t_param_write w;
        w.addr  = addr;
        w.size  = size;
        w.value = value;
        write_q.insert(write_q.size(), w);
        pending_cnt++;
    endtask

    task automatic push_random(input int count);
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        int                sent;
        int                r;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 8)       addr = '0;
            else if (r < 16) addr = '1;
            else             addr = $urandom;
            size = ($urandom_range(0, 99) < 92) ? SIZE_W'($urandom_range(0, 4))
                                                : SIZE_W'($urandom_range(5, 7));
            push_write(addr, size, $urandom);
            sent++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_DEVICE_ID)     dev_id_copy   = data[DEV_W-1:0];
        else if (idx == CFG_MODEL_ID) model_id_copy = data;
    endtask

    task automatic end_reg_writes();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every queued request has been taken and its frame checked
    task automatic drain();
        while (pending_cnt != 0 || frame_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        req_if.valid     = 1'b0;
        req_if.address   = '0;
        req_if.size_code = '0;
        req_if.value     = '0;
        rsp_if.ready     = 1'b0;
        dev_id_copy      = DEVICE_ID_RESET;
        model_id_copy    = MODEL_ID_RESET;
        pending_cnt      = 0;
        err_cnt          = 0;
        idle_cycles      = 0;
        req_calm         = 1'b0;
        rsp_calm         = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed writes under the reset register values
        push_write(32'h0000_0000, SIZE_7BIT, 32'h0000_0000);  // checksum of zero
        push_write(32'hFFFF_FFFF, SIZE_7BIT, 32'hFFFF_FFFF);
        push_write(32'h7F7F_7F7F, SIZE_NIB2, 32'hFFFF_FFFF);
        push_write(32'h7F7F_7F7F, SIZE_NIB3, 32'hFFFF_FFFF);
        push_write(32'h7F7F_7F7F, SIZE_NIB4, 32'hFFFF_FFFF);
        push_write(32'h7F7F_7F7F, SIZE_NIB8, 32'hFFFF_FFFF);
        push_write(32'h8080_8080, SIZE_NIB2, 32'h0000_0000);
        push_write(32'h8080_8080, SIZE_NIB3, 32'h0000_0000);
        push_write(32'h8080_8080, SIZE_NIB4, 32'h0000_0000);
        push_write(32'h8080_8080, SIZE_NIB8, 32'h0000_0000);
        push_write(32'h0102_0304, SIZE_NIB8, 32'h1234_5678);
        push_write(32'hA55A_C33C, SIZE_NIB3, 32'hFFFF_F123);  // upper value bits dropped
        push_write(32'h1234_5678, SIZE_7BIT, 32'h0000_0080);
        push_write(32'hFFFF_FFFF, SIZE_W'(5), 32'hFFFF_FFFF);
        push_write(32'h0000_0000, SIZE_W'(6), 32'h0000_0000);
        push_write(32'h5555_5555, SIZE_W'(7), 32'hAAAA_AAAA);
        push_write(32'h0000_007F, SIZE_7BIT, 32'h0000_007F);
        push_write(32'hFF00_FF00, SIZE_NIB2, 32'h0000_00A5);
        drain();

        // device and model at their upper extremes; spare indexes ignored
        write_reg(CFG_DEVICE_ID, 32'd127);
        write_reg(CFG_MODEL_ID, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_2, 32'h1234_5678);
        write_reg(CFG_SPARE_3, 32'hFFFF_FFFF);
        end_reg_writes();
        push_random(100);
        drain();

        // lower extremes, device data with bits above its width set
        write_reg(CFG_DEVICE_ID, 32'hFFFF_FF80);
        write_reg(CFG_MODEL_ID, 32'h0000_0000);
        end_reg_writes();
        push_random(100);
        drain();

        write_reg(CFG_DEVICE_ID, $urandom);
        write_reg(CFG_MODEL_ID, $urandom);
        end_reg_writes();
        push_random(100);
        drain();

        write_reg(CFG_MODEL_ID, 32'h8081_8283);
        write_reg(CFG_DEVICE_ID, 32'h0000_0055);
        end_reg_writes();
        push_random(100);
        drain();

        if (frame_q.size() != 0)
            $display("ERROR: %0d frame bytes never arrived", frame_q.size());
        if (err_cnt == 0 && frame_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
